>>> design/cht_pkg.sv
// shared types and constants for the coalesced hash table
package cht_pkg;

	localparam int unsigned SLOTS_DEF    = 1024;
	localparam int unsigned KEY_BITS_DEF = 64;
	localparam int unsigned HASH_W       = 32;
	localparam int unsigned CFG_W        = 11;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_DELETE = 2'd2,
		OP_SPARE  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_PRESENT   = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_MOD,
		S_FIND_RD,
		S_FIND_CHK,
		S_DECIDE,
		S_REUSE_RD,
		S_REUSE_CHK,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_TAIL_RD,
		S_TAIL_CHK,
		S_OUT
	} state_t;

endpackage

>>> design/coalesced_hash_table.sv
// coalesced hash table: one item at a time
// flow: the hash modulo (a restoring remainder), then a find walk along the chain from the home slot;
//   an insert of a new key adds a reuse walk of the chain; if that finds no unused slot, a linear
//   probe for a free slot and a tail walk that links the new slot to the end of the chain
// throughput: one item at a time, next accepted the cycle after the result transfer
// reset: arst_n clears control; a clearing pass then writes every slot to zero, emptying the table
module coalesced_hash_table
	import cht_pkg::*;
#(
	parameter int unsigned SLOTS    = SLOTS_DEF,
	parameter int unsigned KEY_BITS = KEY_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_W-1:0]    cfg_wdata,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [63:0]         key,
	input  logic [HASH_W-1:0]   key_hash,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic                found,
	output logic [9:0]          slot,
	output logic [10:0]         entry_count
);

	localparam int unsigned AW = $clog2(SLOTS);
	localparam int unsigned NW = AW + 1;

	// slot memory: key, used flag, link valid, link index
	localparam int unsigned EW = KEY_BITS + 2 + AW;
	logic [EW-1:0] mem [SLOTS];
	logic [EW-1:0] rd_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [EW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_q <= mem[raddr];
	end

	wire [KEY_BITS-1:0] rd_key  = rd_q[EW-1 -: KEY_BITS];
	wire                rd_used = rd_q[AW+1];
	wire                rd_lv   = rd_q[AW];
	wire [AW-1:0]       rd_link = rd_q[AW-1:0];

	state_t state_q, state_d;
	logic [CFG_W-1:0]    tsize_q;
	logic [NW-1:0]       n_q;
	logic [1:0]          op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [HASH_W-1:0]   rem_q;
	logic [5:0]          mcnt_q;
	logic [AW-1:0]       home_q, cur_q, u_q, where_q;
	logic [NW:0]         cnt_q;
	logic                was_q;
	logic [NW-1:0]       count_q;
	logic [1:0]          st_q;
	logic [AW-1:0]       clr_q;

	// active size clamped to 1..SLOTS
	logic [NW-1:0] n_act;
	always_comb begin
		if (tsize_q == '0) n_act = NW'(1);
		else if (32'(tsize_q) > SLOTS) n_act = NW'(SLOTS);
		else n_act = NW'(tsize_q);
	end

	// restoring remainder: one subtract of n shifted per cycle
	logic [HASH_W+NW-1:0] sub_v;
	always_comb sub_v = (HASH_W+NW)'(n_q) << (5'd31 - mcnt_q[4:0]);

	wire [AW-1:0] cur_next_probe = (32'(u_q) + 1 >= 32'(n_q)) ? '0 : u_q + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tsize_q <= CFG_W'(1024);
		end else if (cfg_we) begin
			tsize_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			count_q <= '0;
		end else begin
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			if (state_q == S_DECIDE && op_q == OP_DELETE && was_q && count_q != '0)
				count_q <= count_q - NW'(1);
			if (we && state_q != S_CLEAR && wdata[AW+1] && !(state_q == S_TAIL_CHK))
				count_q <= count_q + NW'(1);
		end
	end

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = cur_q;
		wdata   = rd_q;
		raddr   = cur_q;
		case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				if (32'(clr_q) == SLOTS - 1) state_d = S_IDLE;
			end
			S_IDLE:   if (in_valid) state_d = S_MOD;
			S_MOD:    if (mcnt_q == 6'd32) state_d = S_FIND_RD;
			S_FIND_RD: state_d = S_FIND_CHK;
			S_FIND_CHK: begin
				if ((rd_used && rd_key == key_q) || !rd_lv || cnt_q + 1 >= (NW+1)'(n_q))
					state_d = S_DECIDE;
				else state_d = S_FIND_RD;
			end
			S_DECIDE: begin
				raddr = home_q;
				if (op_q == OP_DELETE && was_q) begin
					we    = 1'b1;
					waddr = where_q;
					wdata = rd_q;
					wdata[AW+1] = 1'b0;
					state_d = S_OUT;
				end else if (op_q == OP_INSERT && !was_q) state_d = S_REUSE_RD;
				else state_d = S_OUT;
			end
			S_REUSE_RD: state_d = S_REUSE_CHK;
			S_REUSE_CHK: begin
				if (!rd_used) begin
					we = 1'b1;
					wdata = {key_q, 1'b1, rd_lv, rd_link};
					state_d = S_OUT;
				end else if (!rd_lv || cnt_q >= (NW+1)'(n_q)) state_d = S_PROBE_RD;
				else state_d = S_REUSE_RD;
			end
			S_PROBE_RD: begin
				raddr = u_q;
				state_d = S_PROBE_CHK;
			end
			S_PROBE_CHK: begin
				if (!rd_used) begin
					we = 1'b1;
					waddr = u_q;
					wdata = {key_q, 1'b1, 1'b0, AW'(0)};
					state_d = S_TAIL_RD;
				end else if (cnt_q + 1 >= (NW+1)'(n_q)) state_d = S_OUT;
				else state_d = S_PROBE_RD;
			end
			S_TAIL_RD: state_d = S_TAIL_CHK;
			S_TAIL_CHK: begin
				if (!rd_lv || 32'(cnt_q) + 1 >= SLOTS) begin
					if (cur_q != u_q && (rd_lv || cur_q != u_q)) begin
						if (!rd_lv) begin
							we = 1'b1;
							wdata = {rd_key, rd_used, 1'b1, u_q};
						end
					end
					state_d = S_OUT;
				end else state_d = S_TAIL_RD;
			end
			S_OUT: if (out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q   <= op;
				key_q  <= key[KEY_BITS-1:0];
				rem_q  <= key_hash;
				mcnt_q <= '0;
				n_q    <= n_act;
				was_q  <= 1'b0;
				where_q <= '0;
			end
			S_MOD: begin
				if (mcnt_q < 6'd32) begin
					if ((HASH_W+NW)'(rem_q) >= sub_v && (sub_v >> (5'd31 - mcnt_q[4:0]))
						== (HASH_W+NW)'(n_q))
						rem_q <= HASH_W'((HASH_W+NW)'(rem_q) - sub_v);
					mcnt_q <= mcnt_q + 6'd1;
				end else begin
					home_q <= AW'(rem_q);
					cur_q  <= AW'(rem_q);
					cnt_q  <= '0;
				end
			end
			S_FIND_CHK: begin
				if (rd_used && rd_key == key_q) begin
					was_q <= 1'b1;
					where_q <= cur_q;
				end else begin
					cur_q <= rd_link;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_DECIDE: begin
				cur_q <= home_q;
				cnt_q <= '0;
				u_q   <= home_q;
				if (op_q == OP_INSERT) st_q <= was_q ? ST_PRESENT : ST_DONE;
				else st_q <= was_q ? ST_DONE : ST_NOT_FOUND;
			end
			S_REUSE_CHK: begin
				if (!rd_used) where_q <= cur_q;
				else if (!rd_lv || cnt_q >= (NW+1)'(n_q)) cnt_q <= '0;
				else begin
					cur_q <= rd_link;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			S_PROBE_CHK: begin
				if (!rd_used) begin
					where_q <= u_q;
					cur_q <= home_q;
					cnt_q <= '0;
				end else begin
					u_q <= cur_next_probe;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q + 1 >= (NW+1)'(n_q)) st_q <= ST_FULL;
				end
			end
			S_TAIL_CHK: begin
				if (rd_lv && 32'(cnt_q) + 1 < SLOTS) begin
					cur_q <= rd_link;
					cnt_q <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	// the reuse walk starts at home itself, so the first read takes home, not its link
	// S_DECIDE reads home into rd_q; S_REUSE_RD then reads cur and CHK inspects it
	// the first REUSE_CHK step reuses home if unused, else follows its link or goes to the probe

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = (state_q == S_OUT);
	assign status      = st_q;
	assign found       = was_q;
	assign slot        = (st_q == ST_FULL || (!was_q && st_q != ST_DONE)) ? 10'd0 : 10'(where_q);
	assign entry_count = 11'(count_q);

	property p_single_owner;
		@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid);
	endproperty
	assert property (p_single_owner) else $error("input and output both open");

	property p_full_no_found;
		@(posedge clk) disable iff (!arst_n) out_valid && status == ST_FULL |-> !found;
	endproperty
	assert property (p_full_no_found) else $error("full with key present");

	property p_count_bound;
		@(posedge clk) disable iff (!arst_n) 32'(count_q) <= SLOTS;
	endproperty
	assert property (p_count_bound) else $error("entry count overflow");

endmodule
